@@ design/bpfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_pkg: shared types and constants for the page frame allocator
// Command codes, controller state type, controller/datapath interface.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    localparam int MAX_PAGES_DEF  = 65536;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int ADDR_W         = 48;
    localparam int CNT_W          = 17;
    localparam logic [CNT_W-1:0] COUNT_MAX   = 17'h1FFFF;
    localparam logic [CNT_W-1:0] TOTAL_RESET = 17'd65536;

    typedef enum logic [2:0] {
        CMD_INIT  = 3'd0,
        CMD_MFREE = 3'd1,
        CMD_MUSED = 3'd2,
        CMD_ALLOC = 3'd3,
        CMD_FREE  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD,
        ST_WAIT,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic rd;
        logic upd;
        logic done;
    } t_ctl;

    typedef struct packed {
        logic clr_last;
        logic single;
        logic span_end;
        logic found;
    } t_sts;

endpackage

@@ design/bpfa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_ctrl: allocator sequencer
// Clearing pass after reset and init, then per-word read/modify/write scan.
// ----------------------------------------------------------------------------
module bpfa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2:0]      i_cmd,
    input  bpfa_pkg::t_sts  i_sts,
    output bpfa_pkg::t_ctl  o_ctl,
    output logic            o_busy
);
    import bpfa_pkg::*;

    t_state r_state, n_state;
    logic   r_init, n_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_init  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
        end
    end

    always_comb begin
        n_state = r_state;
        n_init  = r_init;
        o_ctl   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_init     = (i_cmd == CMD_INIT);
                    if (i_cmd == CMD_INIT) begin
                        n_state = ST_CLEAR;
                    end else if (i_cmd == CMD_MFREE || i_cmd == CMD_MUSED ||
                                 i_cmd == CMD_ALLOC || i_cmd == CMD_FREE) begin
                        n_state = ST_RD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    // the pass after reset has no item and gives no result
                    n_state = r_init ? ST_DONE : ST_IDLE;
                end
            end
            ST_RD: begin
                if (i_sts.span_end) begin
                    n_state = ST_DONE;
                end else begin
                    o_ctl.rd = 1'b1;
                    n_state  = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                o_ctl.upd = 1'b1;
                if (i_sts.single || i_sts.found) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_DONE: begin
                o_ctl.done = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/bpfa_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_dp: allocator datapath
// Usage map memory, page range registers, word update and used counter.
// ----------------------------------------------------------------------------
module bpfa_dp #(
    parameter int MAX_PAGES  = bpfa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = bpfa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bpfa_pkg::t_ctl              i_ctl,
    input  logic [2:0]                  i_cmd,
    input  logic [bpfa_pkg::ADDR_W-1:0] i_phys_addr,
    input  logic [bpfa_pkg::ADDR_W-1:0] i_region_length,
    input  logic                        i_cfg_valid,
    input  logic [bpfa_pkg::CNT_W-1:0]  i_cfg_data,
    output bpfa_pkg::t_sts              o_sts,
    output logic                        o_result_valid,
    output logic [bpfa_pkg::ADDR_W-1:0] o_page_address,
    output logic                        o_no_free_page,
    output logic [bpfa_pkg::CNT_W-1:0]  o_used_count
);
    import bpfa_pkg::*;

    localparam int WORDS = (MAX_PAGES + 63) / 64;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PG_W  = $clog2(MAX_PAGES + 1);
    localparam int SP_W  = ADDR_W + 1 - PAGE_SHIFT;
    localparam logic [SP_W-1:0] MAXP = SP_W'(MAX_PAGES);
    localparam logic [CNT_W-1:0] RST_CNT = (int'(TOTAL_RESET) > MAX_PAGES) ?
                                           CNT_W'(MAX_PAGES) : TOTAL_RESET;

    logic [63:0] mem [WORDS];
    logic [63:0] r_rdata;

    logic [CNT_W-1:0] r_total, r_count, r_lim;
    logic [2:0]       r_cmd;
    logic [SP_W-1:0]  r_cur, r_last;
    logic [WA_W-1:0]  r_clr;
    logic             r_found, r_none;
    logic [PG_W-1:0]  r_fpage;

    logic [SP_W-1:0]   w_first, w_endx, w_lim;
    logic [ADDR_W:0]   w_sum;
    logic [63:0]       w_mask, w_new, w_chg, w_free;
    logic [6:0]        w_nchg;
    logic [5:0]        w_fidx;
    logic              w_fany;
    logic [SP_W-1:0]   w_wbase;
    logic [WA_W-1:0]   w_wa;
    logic [CNT_W-1:0]  w_cnt;

    assign w_first = SP_W'(i_phys_addr >> PAGE_SHIFT);
    assign w_sum   = {1'b0, i_phys_addr} + {1'b0, i_region_length}
                   + (ADDR_W+1)'((1 << PAGE_SHIFT) - 1);
    assign w_endx  = SP_W'(w_sum >> PAGE_SHIFT);
    assign w_lim   = (SP_W'(r_total) > MAXP) ? MAXP : SP_W'(r_total);
    assign w_wa    = WA_W'(r_cur >> 6);
    assign w_wbase = {r_cur[SP_W-1:6], 6'd0};

    always_comb begin
        w_mask = '0;
        for (int b = 0; b < 64; b++) begin
            w_mask[b] = ((w_wbase + SP_W'(b)) >= r_cur) &&
                        ((w_wbase + SP_W'(b)) < r_last);
        end
    end

    always_comb begin
        w_free = ~r_rdata & w_mask;
        w_fany = |w_free;
        w_fidx = '0;
        for (int b = 63; b >= 0; b--) begin
            if (w_free[b]) w_fidx = 6'(b);
        end
        w_new = r_rdata;
        case (r_cmd)
            CMD_MUSED: w_new = r_rdata | w_mask;
            CMD_MFREE, CMD_FREE: w_new = r_rdata & ~w_mask;
            CMD_ALLOC: w_new = r_rdata | (w_fany ? (64'd1 << w_fidx) : 64'd0);
            default: w_new = r_rdata;
        endcase
        w_chg  = w_new ^ r_rdata;
        w_nchg = 7'($countones(w_chg));
        if (r_cmd == CMD_MUSED || r_cmd == CMD_ALLOC) begin
            w_cnt = ({1'b0, r_count} + 18'(w_nchg) > 18'(COUNT_MAX)) ? COUNT_MAX
                  : r_count + CNT_W'(w_nchg);
        end else begin
            w_cnt = (r_count < CNT_W'(w_nchg)) ? '0 : r_count - CNT_W'(w_nchg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_step) begin
            mem[r_clr] <= '1;
        end else if (i_ctl.upd) begin
            mem[w_wa] <= w_new;
        end
        if (i_ctl.rd) begin
            r_rdata <= mem[w_wa];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total        <= TOTAL_RESET;
            r_count        <= RST_CNT;
            r_lim          <= RST_CNT;
            r_clr          <= '0;
            r_found        <= 1'b0;
            r_none         <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_ctl.done;
            if (i_cfg_valid) r_total <= i_cfg_data;
            if (i_ctl.clr_step) begin
                r_clr <= (r_clr == WA_W'(WORDS - 1)) ? '0 : r_clr + 1'b1;
                if (r_clr == WA_W'(WORDS - 1)) r_count <= r_lim;
            end
            if (i_ctl.load) begin
                r_found <= 1'b0;
                r_none  <= (i_cmd == CMD_ALLOC);
                r_lim   <= CNT_W'(w_lim);
            end
            if (i_ctl.upd) begin
                r_count <= w_cnt;
                if (r_cmd == CMD_ALLOC && w_fany) begin
                    r_found <= 1'b1;
                    r_none  <= 1'b0;
                    r_fpage <= PG_W'(w_wbase + SP_W'(w_fidx));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            case (i_cmd)
                CMD_ALLOC: begin
                    r_cur  <= '0;
                    r_last <= w_lim;
                end
                CMD_FREE: begin
                    r_cur  <= w_first;
                    r_last <= (w_first < w_lim) ? w_first + 1'b1 : w_first;
                end
                default: begin
                    r_cur  <= w_first;
                    r_last <= (w_endx > w_lim) ? w_lim : w_endx;
                end
            endcase
        end else if (i_ctl.upd) begin
            r_cur <= w_wbase + SP_W'(64);
        end
    end

    assign o_sts.clr_last = (r_clr == WA_W'(WORDS - 1));
    assign o_sts.single   = (r_cmd == CMD_FREE);
    assign o_sts.span_end = (r_cur >= r_last);
    assign o_sts.found    = (r_cmd == CMD_ALLOC) && w_fany;

    assign o_page_address = r_found ? ADDR_W'(r_fpage) << PAGE_SHIFT : '0;
    assign o_no_free_page = r_none;
    assign o_used_count   = r_count;

    property p_one_hot_ctl;
        @(posedge i_clk) disable iff (!i_rst_n)
            $onehot0({i_ctl.load, i_ctl.clr_step, i_ctl.rd, i_ctl.upd, i_ctl.done});
    endproperty
    a_one_hot_ctl: assert property (p_one_hot_ctl) else $error("ctl overlap");

    property p_rd_then_upd;
        @(posedge i_clk) disable iff (!i_rst_n) i_ctl.rd |=> ##1 i_ctl.upd;
    endproperty
    a_rd_then_upd: assert property (p_rd_then_upd) else $error("upd missing");

    property p_flags;
        @(posedge i_clk) disable iff (!i_rst_n) !(r_found && r_none);
    endproperty
    a_flags: assert property (p_flags) else $error("found and none");

endmodule

@@ design/bitmap_page_frame_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator: first-fit bitmap page allocator
// A scan command loads its range, then reads, waits on and updates each 64-page map word
// in turn to the end of the range; alloc stops at the first free page, free after one word.
// Reset and init run a clearing pass over all (MAX_PAGES+63)/64 map words, busy stays high.
// One result per item, strobed one cycle, receiver cannot stall.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator #(
    parameter int MAX_PAGES  = bpfa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = bpfa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_cmd,
    input  logic [bpfa_pkg::ADDR_W-1:0] i_phys_addr,
    input  logic [bpfa_pkg::ADDR_W-1:0] i_region_length,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bpfa_pkg::CNT_W-1:0]  i_cfg_total_pages,
    output logic                        o_result_valid,
    output logic [bpfa_pkg::ADDR_W-1:0] o_page_address,
    output logic                        o_no_free_page,
    output logic [bpfa_pkg::CNT_W-1:0]  o_used_count
);
    import bpfa_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    bpfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .o_busy  (busy)
    );

    bpfa_dp #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .i_cmd           (i_cmd),
        .i_phys_addr     (i_phys_addr),
        .i_region_length (i_region_length),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_total_pages),
        .o_sts           (w_sts),
        .o_result_valid  (o_result_valid),
        .o_page_address  (o_page_address),
        .o_no_free_page  (o_no_free_page),
        .o_used_count    (o_used_count)
    );

endmodule
